/* hdl/ppp_pkg.sv */
package ppp_pkg;

    localparam int MAX_ELEMENTS = 256;
    localparam int ADDR_W       = 8;
    localparam int COUNT_W      = 9;

    localparam logic [1:0] KIND_CLEAR   = 2'd0;
    localparam logic [1:0] KIND_APPEND  = 2'd1;
    localparam logic [1:0] KIND_PROJECT = 2'd2;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    localparam logic [1:0] EL_MOVE   = 2'd0;
    localparam logic [1:0] EL_LINE   = 2'd1;
    localparam logic [1:0] EL_CLOSE  = 2'd2;
    localparam logic [1:0] EL_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ZERO  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic [1:0] CFG_X_OFFSET = 2'd0;
    localparam logic [1:0] CFG_Y_OFFSET = 2'd1;

    localparam int DIV_STEPS  = 72;
    localparam int SQRT_STEPS = 36;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APP_MUL,
        S_APP_SQRT,
        S_APP_WAIT,
        S_WALK_RD,
        S_WALK_CHK,
        S_PRJ_MUL,
        S_DIVX_GO,
        S_DIVX_WAIT,
        S_DIVY_GO,
        S_DIVY_WAIT
    } state_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] from_x;
        logic signed [31:0] from_y;
        logic signed [31:0] to_x;
        logic signed [31:0] to_y;
        logic [32:0]        length;
    } seg_t;

    typedef struct packed {
        logic go;
        logic sqrt_mode;
    } iter_req_t;

    typedef struct packed {
        logic done;
    } iter_resp_t;

    function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
        logic signed [31:0] r;
        if (v > 42'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -42'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

/* hdl/ppp_iter.sv */
module ppp_iter
    import ppp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  iter_req_t   req,
    input  logic [71:0] num,
    input  logic [32:0] den,
    output iter_resp_t  resp,
    output logic [40:0] result
);

    logic        run_reg, run_next;
    logic        mode_reg, mode_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [71:0] n_reg, n_next;
    logic [36:0] r_reg, r_next;
    logic [71:0] q_reg, q_next;
    logic [32:0] d_reg, d_next;

    logic [33:0] div_r2;
    logic [36:0] sq_r2;
    logic [36:0] sq_trial;
    logic [6:0]  last_cnt;

    always_comb
    begin
        div_r2   = {r_reg[32:0], n_reg[71]};
        sq_r2    = {r_reg[34:0], n_reg[71:70]};
        sq_trial = {q_reg[34:0], 2'b01};
        last_cnt = mode_reg ? 7'(SQRT_STEPS - 1) : 7'(DIV_STEPS - 1);

        run_next  = run_reg;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        n_next    = n_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        d_next    = d_reg;

        if (req.go) begin
            run_next  = 1'b1;
            mode_next = req.sqrt_mode;
            cnt_next  = '0;
            n_next    = num;
            r_next    = '0;
            q_next    = '0;
            d_next    = den;
        end else if (run_reg) begin
            if (mode_reg) begin
                // one root digit per step, two radicand bits in
                n_next = {n_reg[69:0], 2'b00};
                if (sq_r2 >= sq_trial) begin
                    r_next = sq_r2 - sq_trial;
                    q_next = {q_reg[70:0], 1'b1};
                end else begin
                    r_next = sq_r2;
                    q_next = {q_reg[70:0], 1'b0};
                end
            end else begin
                n_next = {n_reg[70:0], 1'b0};
                if (div_r2 >= {1'b0, d_reg}) begin
                    r_next = {3'b000, div_r2 - {1'b0, d_reg}};
                    q_next = {q_reg[70:0], 1'b1};
                end else begin
                    r_next = {3'b000, div_r2};
                    q_next = {q_reg[70:0], 1'b0};
                end
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == last_cnt) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            mode_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        r_reg <= r_next;
        q_reg <= q_next;
        d_reg <= d_next;
    end

    // quotient magnitude is capped at 2^40
    always_comb
    begin
        if (!mode_reg && (q_reg > 72'h100_0000_0000))
            result = 41'h100_0000_0000;
        else
            result = q_reg[40:0];
        resp.done = done_reg;
    end

endmodule

/* hdl/polyline_point_projector.sv */
// Polyline point projector. Command interface: an item is taken when start is high and busy
// is low; its one result appears on x_out, y_out and status for a single cycle with done high
// and must be captured then, since the receiver cannot stall. Clear and rejected commands are
// answered without leaving the idle state. An append runs two passes through the shared
// multiplier and a 36-step square root in the iterative unit. A projection reads one walked
// element at a time from the segment memory (synchronous read), then forms the four products
// and runs two 72-step divisions; a full store holds 256 elements.
module polyline_point_projector
    import ppp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         kind,
    input  logic [1:0]         element_type,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               done,
    output logic signed [31:0] x_out,
    output logic signed [31:0] y_out,
    output logic [1:0]         status
);

    state_t state_reg, state_next;

    logic [COUNT_W-1:0] count_reg;
    logic signed [31:0] cur_x_reg, cur_y_reg, st_x_reg, st_y_reg;
    logic               known_reg;
    logic signed [31:0] xoff_reg, yoff_reg;

    logic               done_reg;
    logic signed [31:0] xo_reg, yo_reg, xres_reg;
    logic [1:0]         status_reg;

    logic [2:0]         cnt_reg;
    logic [ADDR_W-1:0]  i_reg;
    logic signed [33:0] rem_reg;
    logic signed [32:0] tx_reg, ty_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic signed [69:0] prod_reg;
    logic signed [71:0] accx_reg, accy_reg;
    seg_t               wseg_reg;
    seg_t               seg_reg;

    seg_t mem [MAX_ELEMENTS];

    logic               accept;
    logic signed [34:0] mul_a, mul_b;
    logic signed [71:0] prod_ext;
    iter_req_t          ireq;
    iter_resp_t         iresp;
    logic [71:0]        inum;
    logic [40:0]        ires;
    logic               mem_we;
    logic               walk_more;
    logic               app_ok;
    logic signed [32:0] ptx, pty;
    logic signed [32:0] afx, afy, atx, aty;
    logic signed [41:0] q_signed;
    logic signed [41:0] outx_sum, outy_sum;

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign prod_ext  = 72'(prod_reg);

    assign app_ok = (element_type != EL_UNUSED) && (count_reg < COUNT_W'(MAX_ELEMENTS))
                    && ((element_type == EL_MOVE) || known_reg);

    assign ptx = 33'(point_x) + 33'(xoff_reg);
    assign pty = 33'(point_y) + 33'(yoff_reg);

    assign walk_more = ((9'(i_reg) + 9'd1) < count_reg)
                       && ((rem_reg > $signed({1'b0, seg_reg.length}))
                           || (seg_reg.kind == EL_MOVE));

    always_comb
    begin
        afx = (element_type == EL_MOVE) ? 33'(point_x) : 33'(cur_x_reg);
        afy = (element_type == EL_MOVE) ? 33'(point_y) : 33'(cur_y_reg);
        atx = (element_type == EL_CLOSE) ? 33'(st_x_reg) : 33'(point_x);
        aty = (element_type == EL_CLOSE) ? 33'(st_y_reg) : 33'(point_y);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept) begin
                    if ((kind == KIND_APPEND) && app_ok)
                        state_next = S_APP_MUL;
                    else if ((kind == KIND_PROJECT) && (count_reg != '0))
                        state_next = S_WALK_RD;
                end
            end
            S_APP_MUL:   if (cnt_reg == 3'd2) state_next = S_APP_SQRT;
            S_APP_SQRT:  state_next = S_APP_WAIT;
            S_APP_WAIT:  if (iresp.done) state_next = S_IDLE;
            S_WALK_RD:   state_next = S_WALK_CHK;
            S_WALK_CHK:
            begin
                if (walk_more)
                    state_next = S_WALK_RD;
                else if ((seg_reg.kind == EL_MOVE) || (seg_reg.length == '0))
                    state_next = S_IDLE;
                else
                    state_next = S_PRJ_MUL;
            end
            S_PRJ_MUL:   if (cnt_reg == 3'd4) state_next = S_DIVX_GO;
            S_DIVX_GO:   state_next = S_DIVX_WAIT;
            S_DIVX_WAIT: if (iresp.done) state_next = S_DIVY_GO;
            S_DIVY_GO:   state_next = S_DIVY_WAIT;
            S_DIVY_WAIT: if (iresp.done) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // control outputs and operand selection
    always_comb
    begin
        busy           = (state_reg != S_IDLE);
        ireq.go        = 1'b0;
        ireq.sqrt_mode = 1'b0;
        inum           = '0;
        mul_a          = 35'(dx_reg);
        mul_b          = 35'(dx_reg);
        mem_we         = 1'b0;
        unique case (state_reg)
            S_APP_MUL:
            begin
                if (cnt_reg == 3'd1) begin
                    mul_a = 35'(dy_reg);
                    mul_b = 35'(dy_reg);
                end
            end
            S_APP_SQRT:
            begin
                ireq.go        = 1'b1;
                ireq.sqrt_mode = 1'b1;
                inum           = accx_reg;
            end
            S_APP_WAIT: mem_we = iresp.done;
            S_PRJ_MUL:
            begin
                case (cnt_reg)
                    3'd0:
                    begin
                        mul_a = 35'(dx_reg);
                        mul_b = 35'(rem_reg);
                    end
                    3'd1:
                    begin
                        mul_a = -35'(dy_reg);
                        mul_b = 35'(ty_reg);
                    end
                    3'd2:
                    begin
                        mul_a = 35'(dy_reg);
                        mul_b = 35'(rem_reg);
                    end
                    default:
                    begin
                        mul_a = 35'(dx_reg);
                        mul_b = 35'(ty_reg);
                    end
                endcase
            end
            S_DIVX_GO:
            begin
                ireq.go = 1'b1;
                inum    = accx_reg[71] ? 72'(-accx_reg) : 72'(accx_reg);
            end
            S_DIVY_GO:
            begin
                ireq.go = 1'b1;
                inum    = accy_reg[71] ? 72'(-accy_reg) : 72'(accy_reg);
            end
            default:
            begin
                busy = (state_reg != S_IDLE);
            end
        endcase
    end

    always_comb
    begin
        if (state_reg == S_DIVX_WAIT)
            q_signed = accx_reg[71] ? -42'(ires) : 42'(ires);
        else
            q_signed = accy_reg[71] ? -42'(ires) : 42'(ires);
        outx_sum = 42'(seg_reg.from_x) + q_signed;
        outy_sum = 42'(seg_reg.from_y) + q_signed;
    end

    ppp_iter u_iter
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (ireq),
        .num    (inum),
        .den    (seg_reg.length),
        .resp   (iresp),
        .result (ires)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[count_reg[ADDR_W-1:0]] <= {wseg_reg[162:33], ires[32:0]};
        seg_reg <= mem[i_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            st_x_reg   <= '0;
            st_y_reg   <= '0;
            known_reg  <= 1'b0;
            xoff_reg   <= '0;
            yoff_reg   <= '0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_X_OFFSET: xoff_reg <= cfg_data;
                    CFG_Y_OFFSET: yoff_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (accept) begin
                cnt_reg <= '0;
                unique case (kind)
                    KIND_CLEAR:
                    begin
                        count_reg <= '0;
                        cur_x_reg <= '0;
                        cur_y_reg <= '0;
                        st_x_reg  <= '0;
                        st_y_reg  <= '0;
                        known_reg <= 1'b0;
                    end
                    KIND_APPEND:
                    begin
                        if (app_ok && (element_type == EL_MOVE)) begin
                            st_x_reg  <= point_x;
                            st_y_reg  <= point_y;
                            known_reg <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end

            if ((state_reg == S_APP_MUL) || (state_reg == S_PRJ_MUL))
                cnt_reg <= cnt_reg + 3'd1;

            if (mem_we) begin
                cur_x_reg <= wseg_reg.to_x;
                cur_y_reg <= wseg_reg.to_y;
                count_reg <= count_reg + 9'd1;
            end

            if ((state_reg == S_IDLE) && accept) begin
                done_reg <= !((kind == KIND_APPEND) && app_ok)
                            && !((kind == KIND_PROJECT) && (count_reg != '0));
            end else if ((state_reg == S_APP_WAIT) && iresp.done) begin
                done_reg <= 1'b1;
            end else if ((state_reg == S_WALK_CHK) && !walk_more
                         && ((seg_reg.kind == EL_MOVE) || (seg_reg.length == '0))) begin
                done_reg <= 1'b1;
            end else if ((state_reg == S_DIVY_WAIT) && iresp.done) begin
                done_reg <= 1'b1;
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        if (accept) begin
            xo_reg <= '0;
            yo_reg <= '0;
            if (kind == KIND_APPEND) begin
                if (element_type == EL_UNUSED)
                    status_reg <= ST_OK;
                else if (count_reg >= COUNT_W'(MAX_ELEMENTS))
                    status_reg <= ST_FULL;
                else if ((element_type != EL_MOVE) && !known_reg)
                    status_reg <= ST_EMPTY;
                else
                    status_reg <= ST_OK;
                wseg_reg.kind   <= element_type;
                wseg_reg.from_x <= afx[31:0];
                wseg_reg.from_y <= afy[31:0];
                wseg_reg.to_x   <= atx[31:0];
                wseg_reg.to_y   <= aty[31:0];
                wseg_reg.length <= '0;
                dx_reg          <= atx - afx;
                dy_reg          <= aty - afy;
            end else if (kind == KIND_PROJECT) begin
                status_reg <= (count_reg == '0) ? ST_EMPTY : ST_OK;
                tx_reg  <= ptx;
                ty_reg  <= pty;
                rem_reg <= 34'(ptx);
                i_reg   <= '0;
            end else begin
                status_reg <= ST_OK;
            end
        end

        if (state_reg == S_APP_MUL) begin
            if (cnt_reg == 3'd1)
                accx_reg <= prod_ext;
            else if (cnt_reg == 3'd2)
                accx_reg <= accx_reg + prod_ext;
        end

        if (state_reg == S_WALK_CHK) begin
            if (walk_more) begin
                rem_reg <= rem_reg - $signed({1'b0, seg_reg.length});
                i_reg   <= i_reg + 8'd1;
            end else if (seg_reg.kind == EL_MOVE) begin
                xo_reg <= sat32(42'(tx_reg));
                yo_reg <= sat32(42'(ty_reg));
            end else if (seg_reg.length == '0) begin
                xo_reg     <= seg_reg.from_x;
                yo_reg     <= seg_reg.from_y;
                status_reg <= ST_ZERO;
            end else begin
                dx_reg <= 33'(seg_reg.to_x) - 33'(seg_reg.from_x);
                dy_reg <= 33'(seg_reg.to_y) - 33'(seg_reg.from_y);
            end
        end

        if (state_reg == S_PRJ_MUL) begin
            case (cnt_reg)
                3'd1: accx_reg <= prod_ext;
                3'd2: accx_reg <= accx_reg + prod_ext;
                3'd3: accy_reg <= prod_ext;
                3'd4: accy_reg <= accy_reg + prod_ext;
                default: ;
            endcase
        end

        if ((state_reg == S_DIVX_WAIT) && iresp.done)
            xres_reg <= sat32(outx_sum);

        if ((state_reg == S_DIVY_WAIT) && iresp.done) begin
            xo_reg <= xres_reg;
            yo_reg <= sat32(outy_sum);
        end
    end

    assign done   = done_reg;
    assign x_out  = xo_reg;
    assign y_out  = yo_reg;
    assign status = status_reg;

endmodule

/* tb/sv/ppp_checker.sv */
`timescale 1ns / 100ps

module ppp_checker
    import ppp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         kind,
    input  logic [1:0]         element_type,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               done,
    input  logic signed [31:0] x_out,
    input  logic signed [31:0] y_out,
    input  logic [1:0]         status,
    output int                 fail_count,
    output int                 pending
);

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [1:0]         st;
    } proj_result_t;

    localparam longint QUOT_CAP = 64'sd1 << 40;

    proj_result_t result_q[$];

    // shadow of the path store and pen
    logic [1:0]  path_kind [MAX_ELEMENTS];
    longint      path_fx   [MAX_ELEMENTS];
    longint      path_fy   [MAX_ELEMENTS];
    longint      path_tx   [MAX_ELEMENTS];
    longint      path_ty   [MAX_ELEMENTS];
    longint      path_len  [MAX_ELEMENTS];
    int          path_count;
    longint      pen_x, pen_y, first_x, first_y;
    bit          have_start;
    longint      off_x, off_y;

    assign pending = result_q.size();

    function automatic longint isqrt66(logic [65:0] s);
        logic [33:0]  r;
        logic [33:0]  c;
        logic [67:0]  sq;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            c = r | (34'd1 << b);
            sq = c * c;
            if (sq <= {2'b00, s})
                r = c;
        end
        return longint'({30'd0, r});
    endfunction

    function automatic longint div_capped(logic signed [127:0] n, longint d);
        logic [127:0] mag;
        logic [127:0] q;
        longint       qv;
        mag = n[127] ? -n : n;
        q = mag / 128'(d);
        qv = (q > 128'(QUOT_CAP)) ? QUOT_CAP : longint'(q[63:0]);
        return n[127] ? -qv : qv;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic [1:0] append_elem(logic [1:0] et, longint px, longint py);
        longint fx, fy, tx, ty, dx, dy;
        logic [63:0] mx, my;
        logic [65:0] sum;
        if (et > EL_CLOSE)
            return ST_OK;
        if (path_count >= MAX_ELEMENTS)
            return ST_FULL;
        if (et != EL_MOVE && !have_start)
            return ST_EMPTY;
        if (et == EL_MOVE) begin
            fx = px; fy = py; tx = px; ty = py;
            first_x = px; first_y = py;
            have_start = 1'b1;
        end else if (et == EL_LINE) begin
            fx = pen_x; fy = pen_y; tx = px; ty = py;
        end else begin
            fx = pen_x; fy = pen_y; tx = first_x; ty = first_y;
        end
        dx = tx - fx;
        dy = ty - fy;
        // squares of up to 32-bit magnitudes do not fit a signed 64-bit value
        mx = (dx < 0) ? 64'(-dx) : 64'(dx);
        my = (dy < 0) ? 64'(-dy) : 64'(dy);
        sum = {2'b00, mx * mx} + {2'b00, my * my};
        path_kind[path_count] = et;
        path_fx[path_count] = fx;
        path_fy[path_count] = fy;
        path_tx[path_count] = tx;
        path_ty[path_count] = ty;
        path_len[path_count] = isqrt66(sum);
        pen_x = tx;
        pen_y = ty;
        path_count++;
        return ST_OK;
    endfunction

    function automatic proj_result_t project_point(longint px, longint py);
        proj_result_t r;
        longint tx, ty, rem, dx, dy, len;
        logic signed [127:0] nx, ny;
        int i;
        r.x = '0; r.y = '0; r.st = ST_OK;
        tx = px + off_x;
        ty = py + off_y;
        rem = tx;
        i = 0;
        if (path_count == 0) begin
            r.st = ST_EMPTY;
            return r;
        end
        while (i + 1 < path_count && (rem > path_len[i] || path_kind[i] == EL_MOVE)) begin
            rem -= path_len[i];
            i++;
        end
        if (path_kind[i] == EL_MOVE) begin
            r.x = clamp32(tx);
            r.y = clamp32(ty);
            return r;
        end
        len = path_len[i];
        if (len == 0) begin
            r.x = clamp32(path_fx[i]);
            r.y = clamp32(path_fy[i]);
            r.st = ST_ZERO;
            return r;
        end
        dx = path_tx[i] - path_fx[i];
        dy = path_ty[i] - path_fy[i];
        nx = 128'(dx) * 128'(rem) - 128'(dy) * 128'(ty);
        ny = 128'(dy) * 128'(rem) + 128'(dx) * 128'(ty);
        r.x = clamp32(path_fx[i] + div_capped(nx, len));
        r.y = clamp32(path_fy[i] + div_capped(ny, len));
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        proj_result_t exp_r;
        proj_result_t got;
        if (!rst_n) begin
            path_count = 0;
            pen_x = 0; pen_y = 0; first_x = 0; first_y = 0;
            have_start = 1'b0;
            off_x = 0; off_y = 0;
            fail_count = 0;
            result_q.delete();
        end else begin
            if (done) begin
                if (result_q.size() == 0) begin
                    $error("result with no transfer outstanding");
                    fail_count++;
                end else begin
                    got = result_q.pop_front();
                    if (x_out !== got.x) begin
                        $error("x_out expected %0d actual %0d", got.x, x_out);
                        fail_count++;
                    end
                    if (y_out !== got.y) begin
                        $error("y_out expected %0d actual %0d", got.y, y_out);
                        fail_count++;
                    end
                    if (status !== got.st) begin
                        $error("status expected %0d actual %0d", got.st, status);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_X_OFFSET)
                    off_x = longint'($signed(cfg_data));
                else if (cfg_index == CFG_Y_OFFSET)
                    off_y = longint'($signed(cfg_data));
            end
            if (start && !busy) begin
                exp_r.x = '0; exp_r.y = '0; exp_r.st = ST_OK;
                if (kind == KIND_CLEAR) begin
                    path_count = 0;
                    pen_x = 0; pen_y = 0; first_x = 0; first_y = 0;
                    have_start = 1'b0;
                end else if (kind == KIND_APPEND) begin
                    exp_r.st = append_elem(element_type, longint'(point_x),
                                           longint'(point_y));
                end else if (kind == KIND_PROJECT) begin
                    exp_r = project_point(longint'(point_x), longint'(point_y));
                end
                result_q.push_back(exp_r);
            end
        end
    end

    final
    begin
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import ppp_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         kind;
    logic [1:0]         element_type;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               done;
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic [1:0]         status;
    int                 fail_count;
    int                 pending;
    int                 item_count;
    int                 burst_left;

    polyline_point_projector dut (.*);

    ppp_checker u_checker (.*);

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    initial
    begin
        #20000000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
            1, 2: return $urandom;
            default: return $urandom_range(0, 32'h1fffff) - 32'h100000;
        endcase
    endfunction

    // holds start high across a burst, drops it for a random gap in between
    task automatic send_item(input logic [1:0] k, input logic [1:0] et,
                             input logic [31:0] px, input logic [31:0] py);
        int gap;
        @(negedge clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                start = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        start = 1'b1;
        kind = k;
        element_type = et;
        point_x = px;
        point_y = py;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        item_count++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_offsets(input logic [31:0] xo, input logic [31:0] yo);
        wait_drained();
        write_reg(CFG_X_OFFSET, xo);
        write_reg(CFG_Y_OFFSET, yo);
    endtask

    task automatic fill_store();
        send_item(KIND_CLEAR, EL_MOVE, 0, 0);
        send_item(KIND_APPEND, EL_MOVE, rand_coord(), rand_coord());
        for (int i = 1; i < MAX_ELEMENTS; i++)
            send_item(KIND_APPEND, logic'($urandom_range(0, 1)) ? EL_LINE : EL_CLOSE,
                      $urandom_range(0, 32'hffff), $urandom_range(0, 32'hffff));
        send_item(KIND_APPEND, EL_LINE, 32'h10000, 32'h10000);
        repeat (6)
            send_item(KIND_PROJECT, EL_MOVE, $urandom_range(0, 32'h3fffffff), rand_coord());
    endtask

    // well-formed path with random content, then projections along it
    task automatic path_sequence();
        int n_seg;
        int n_proj;
        n_seg = $urandom_range(1, 8);
        n_proj = $urandom_range(2, 10);
        send_item(KIND_CLEAR, EL_MOVE, $urandom, $urandom);
        send_item(KIND_APPEND, EL_MOVE, rand_coord(), rand_coord());
        for (int i = 0; i < n_seg; i++) begin
            case ($urandom_range(0, 9))
                0: send_item(KIND_APPEND, EL_CLOSE, $urandom, $urandom);
                1: send_item(KIND_APPEND, EL_MOVE, rand_coord(), rand_coord());
                2: send_item(KIND_APPEND, EL_UNUSED, $urandom, $urandom);
                default: send_item(KIND_APPEND, EL_LINE, rand_coord(), rand_coord());
            endcase
        end
        for (int i = 0; i < n_proj; i++) begin
            if ($urandom_range(0, 2) == 0)
                send_item(KIND_PROJECT, 2'($urandom), rand_coord(), rand_coord());
            else
                send_item(KIND_PROJECT, 2'($urandom),
                          $urandom_range(0, 32'h4fffff) - 32'h80000,
                          $urandom_range(0, 32'h3ffff) - 32'h20000);
        end
        if ($urandom_range(0, 7) == 0)
            send_item(KIND_UNUSED, 2'($urandom), $urandom, $urandom);
        if ($urandom_range(0, 7) == 0)
            send_item(KIND_APPEND, EL_LINE, rand_coord(), rand_coord());
    endtask

    initial
    begin
        int limit;
        start = 1'b0;
        kind = KIND_CLEAR;
        element_type = EL_MOVE;
        point_x = '0;
        point_y = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_X_OFFSET;
        cfg_data = '0;
        item_count = 0;
        burst_left = 0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty path, line before move, unused codes, zero length
        send_item(KIND_PROJECT, EL_MOVE, 32'h7fffffff, 32'h80000000);
        send_item(KIND_APPEND, EL_LINE, 32'h10000, 0);
        send_item(KIND_APPEND, EL_CLOSE, 0, 0);
        send_item(KIND_APPEND, EL_UNUSED, 32'hffffffff, 32'hffffffff);
        send_item(KIND_UNUSED, EL_UNUSED, 32'hffffffff, 32'hffffffff);
        send_item(KIND_APPEND, EL_MOVE, 0, 0);
        send_item(KIND_PROJECT, EL_MOVE, 32'h10000, 32'h10000);
        send_item(KIND_APPEND, EL_LINE, 0, 0);
        send_item(KIND_PROJECT, EL_MOVE, 32'h10000, 0);
        send_item(KIND_APPEND, EL_LINE, 32'h30000, 32'h40000);
        send_item(KIND_APPEND, EL_LINE, 32'h80000000, 32'h7fffffff);
        send_item(KIND_APPEND, EL_CLOSE, 0, 0);
        send_item(KIND_PROJECT, EL_MOVE, 32'h20000, 32'h10000);
        send_item(KIND_PROJECT, EL_MOVE, 32'hfffe0000, 32'hffff0000);
        send_item(KIND_PROJECT, EL_MOVE, 32'h7fffffff, 32'h7fffffff);
        send_item(KIND_PROJECT, EL_MOVE, 32'h80000000, 32'h80000000);
        send_item(KIND_CLEAR, EL_MOVE, 0, 0);
        send_item(KIND_PROJECT, EL_MOVE, 0, 0);
        send_item(KIND_APPEND, EL_MOVE, 32'h7fffffff, 32'h80000000);
        send_item(KIND_APPEND, EL_LINE, 32'h80000000, 32'h7fffffff);
        send_item(KIND_PROJECT, EL_MOVE, 32'h12345678, 32'h7fffffff);

        set_offsets(32'h7fffffff, 32'h80000000);
        send_item(KIND_PROJECT, EL_MOVE, 32'h7fffffff, 32'h80000000);
        send_item(KIND_PROJECT, EL_MOVE, 32'h80000000, 32'h7fffffff);
        set_offsets(32'h80000000, 32'h7fffffff);
        send_item(KIND_PROJECT, EL_MOVE, 32'h80000000, 32'h7fffffff);

        set_offsets(0, 0);
        fill_store();

        while (item_count < 1500) begin
            if ($urandom_range(0, 5) == 0) begin
                case ($urandom_range(0, 3))
                    0: set_offsets(0, 0);
                    1: set_offsets($urandom, $urandom);
                    default: set_offsets($urandom_range(0, 32'h3ffff) - 32'h20000,
                                         $urandom_range(0, 32'h3ffff) - 32'h20000);
                endcase
            end
            if ($urandom_range(0, 150) == 0)
                fill_store();
            else if ($urandom_range(0, 9) == 0)
                send_item(2'($urandom), 2'($urandom), $urandom, $urandom);
            else
                path_sequence();
        end

        @(negedge clk);
        start = 1'b0;
        limit = 0;
        while (pending != 0 && limit < 100000) begin
            @(negedge clk);
            limit++;
        end
        repeat (700) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
